// ===== hw/rtl/grid_box_neighbor_cells_macros.svh =====
// Assertion helpers for the top-level RTL, grid_box_neighbor_cells.sv.
`ifndef GRID_BOX_NEIGHBOR_CELLS_MACROS_SVH
`define GRID_BOX_NEIGHBOR_CELLS_MACROS_SVH

// Check prop on every clock edge outside reset.
`define GBNC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check prop on every clock edge, reset included.
`define GBNC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/gbnc_pkg.sv =====
package gbnc_pkg;

  localparam int DIM_W   = 11;
  localparam int COORD_W = 12;
  localparam int CELL_W  = 10;
  localparam int ID_W    = 30;
  localparam int DXY_W   = 2 * CELL_W + 1;
  localparam int YOFF_W  = 2 * CELL_W;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_DIM    = 1024;
  localparam int MAX_RADIUS = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUND,
    ST_MUL,
    ST_SUM,
    ST_EMIT
  } gbnc_state_t;

  typedef struct packed {
    logic load;
    logic bound;
    logic mul;
    logic init;
    logic step;
  } gbnc_cmd_t;

  typedef struct packed {
    logic in_grid;
    logic box_end;
  } gbnc_status_t;

endpackage

// ===== hw/rtl/gbnc_ctrl.sv =====
module gbnc_ctrl
  import gbnc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  gbnc_status_t status,
  output gbnc_cmd_t    cmd
);

  gbnc_state_t state_r;
  gbnc_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_BOUND;
      ST_BOUND: state_nxt = status.in_grid ? ST_MUL : ST_IDLE;
      ST_MUL:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_EMIT;
      ST_EMIT:  if (!out_stall && status.box_end) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_BOUND: cmd.bound = 1'b1;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_SUM:   cmd.init  = 1'b1;
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.step  = !out_stall && !status.box_end;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/gbnc_dpath.sv =====
module gbnc_dpath
  import gbnc_pkg::*;
#(
  parameter int DIM_LIMIT    = MAX_DIM,
  parameter int RADIUS_LIMIT = MAX_RADIUS
)
(
  input  logic               clk,
  input  gbnc_cmd_t          cmd,
  output gbnc_status_t       status,
  input  logic [DIM_W-1:0]   dim_x,
  input  logic [DIM_W-1:0]   dim_y,
  input  logic [DIM_W-1:0]   dim_z,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [COORD_W-1:0] coord_z,
  input  logic               radius,
  output logic [ID_W-1:0]    cell_id,
  output logic [CELL_W-1:0]  cell_x,
  output logic [CELL_W-1:0]  cell_y,
  output logic [CELL_W-1:0]  cell_z,
  output logic               last
);

  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_LIMIT);
  localparam logic             R_EN    = (RADIUS_LIMIT > 0);

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    return (d > DIM_CAP) ? DIM_CAP : d;
  endfunction

  // Clamp one axis of the box around p to [0, d-1].
  function automatic logic [2*CELL_W-1:0] axis_box(input logic [CELL_W-1:0] p,
                                                   input logic r,
                                                   input logic [DIM_W-1:0] d);
    logic [CELL_W-1:0] lo;
    logic [CELL_W-1:0] hi;
    lo = (r && p != '0) ? p - CELL_W'(1) : p;
    hi = (r && ({1'b0, p} + DIM_W'(1)) < d) ? p + CELL_W'(1) : p;
    return {lo, hi};
  endfunction

  logic [DIM_W-1:0] dx, dy, dz;
  logic [COORD_W-1:0] px_r, py_r, pz_r;
  logic               r_r;
  logic [CELL_W-1:0]  x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;
  logic [DXY_W-1:0]   dxy_r;
  logic [YOFF_W-1:0]  yoff_r;
  logic [ID_W-1:0]    zoff_r;
  logic [CELL_W-1:0]  x_r, y_r, z_r;
  logic [ID_W-1:0]    id_r, row_r, plane_r;

  logic [2*CELL_W-1:0] bx, by, bz;
  logic [DXY_W-1:0]    dxy_full;
  logic [YOFF_W-1:0]   yoff_full;
  logic [ID_W-1:0]     zoff_full;
  logic [ID_W-1:0]     base, row_nxt, plane_nxt;
  logic                x_end, y_end, z_end;

  assign dx = eff_dim(dim_x);
  assign dy = eff_dim(dim_y);
  assign dz = eff_dim(dim_z);

  assign status.in_grid = !px_r[COORD_W-1] && (px_r[DIM_W-1:0] < dx) &&
                          !py_r[COORD_W-1] && (py_r[DIM_W-1:0] < dy) &&
                          !pz_r[COORD_W-1] && (pz_r[DIM_W-1:0] < dz);

  assign bx = axis_box(px_r[CELL_W-1:0], r_r, dx);
  assign by = axis_box(py_r[CELL_W-1:0], r_r, dy);
  assign bz = axis_box(pz_r[CELL_W-1:0], r_r, dz);

  // Products stay inside the target widths for dimensions up to the cap.
  assign dxy_full  = DXY_W'(dx) * DXY_W'(dy);
  assign yoff_full = YOFF_W'(y0_r) * YOFF_W'(dx);
  assign zoff_full = ID_W'(z0_r) * ID_W'(dxy_r);
  assign base      = ID_W'(yoff_r) + zoff_r;

  assign x_end = (x_r == x1_r);
  assign y_end = (y_r == y1_r);
  assign z_end = (z_r == z1_r);
  assign status.box_end = x_end && y_end && z_end;

  assign row_nxt   = row_r + ID_W'(dx);
  assign plane_nxt = plane_r + ID_W'(dxy_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= coord_x;
      py_r <= coord_y;
      pz_r <= coord_z;
      r_r  <= radius & R_EN;
    end
    if (cmd.bound) begin
      {x0_r, x1_r} <= bx;
      {y0_r, y1_r} <= by;
      {z0_r, z1_r} <= bz;
      dxy_r        <= dxy_full;
    end
    if (cmd.mul) begin
      yoff_r <= yoff_full;
      zoff_r <= zoff_full;
    end
    if (cmd.init) begin
      x_r     <= x0_r;
      y_r     <= y0_r;
      z_r     <= z0_r;
      id_r    <= base + ID_W'(x0_r);
      row_r   <= base;
      plane_r <= base;
    end else if (cmd.step) begin
      if (!x_end) begin
        x_r  <= x_r + CELL_W'(1);
        id_r <= id_r + ID_W'(1);
      end else if (!y_end) begin
        // wrap x, advance to the next row
        x_r   <= x0_r;
        y_r   <= y_r + CELL_W'(1);
        row_r <= row_nxt;
        id_r  <= row_nxt + ID_W'(x0_r);
      end else begin
        // wrap x and y, advance to the next plane
        x_r     <= x0_r;
        y_r     <= y0_r;
        z_r     <= z_r + CELL_W'(1);
        plane_r <= plane_nxt;
        row_r   <= plane_nxt;
        id_r    <= plane_nxt + ID_W'(x0_r);
      end
    end
  end

  assign cell_id = id_r;
  assign cell_x  = x_r;
  assign cell_y  = y_r;
  assign cell_z  = z_r;
  assign last    = status.box_end;

endmodule

// ===== hw/rtl/grid_box_neighbor_cells.sv =====
// The query beat is registered, then the bound, multiply and sum setup states run before
//   the first result beat. A query inside the grid gives N results (N = box cells, up to 27),
//   one result a cycle from the id stepper while out_stall is low; a query outside
//   the grid gives no result. in_stall is high outside idle, so a new query waits until
//   the last result is taken and the controller is back in idle.
// Reset (rst_n low, synchronous): controller idle, dim_x/dim_y/dim_z set to 1.
`include "grid_box_neighbor_cells_macros.svh"

module grid_box_neighbor_cells
  import gbnc_pkg::*;
#(
  parameter int DIM_LIMIT    = MAX_DIM,
  parameter int RADIUS_LIMIT = MAX_RADIUS
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COORD_W-1:0]   in_coord_x,
  input  logic [COORD_W-1:0]   in_coord_y,
  input  logic [COORD_W-1:0]   in_coord_z,
  input  logic                 in_radius,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ID_W-1:0]      out_cell_id,
  output logic [CELL_W-1:0]    out_cell_x,
  output logic [CELL_W-1:0]    out_cell_y,
  output logic [CELL_W-1:0]    out_cell_z,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0] dim_x_r, dim_y_r, dim_z_r;
  logic [DIM_W-1:0] dim_x_nxt, dim_y_nxt, dim_z_nxt;
  gbnc_cmd_t        cmd;
  gbnc_status_t     status;
  logic             cell_in_grid;

  assign cfg_ready = 1'b1;

  // Unknown indexes are dropped.
  always_comb begin
    dim_x_nxt = dim_x_r;
    dim_y_nxt = dim_y_r;
    dim_z_nxt = dim_z_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIM_X: dim_x_nxt = cfg_data;
        CFG_DIM_Y: dim_y_nxt = cfg_data;
        CFG_DIM_Z: dim_z_nxt = cfg_data;
        default:   dim_x_nxt = dim_x_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r <= DIM_W'(1);
      dim_y_r <= DIM_W'(1);
      dim_z_r <= DIM_W'(1);
    end else begin
      dim_x_r <= dim_x_nxt;
      dim_y_r <= dim_y_nxt;
      dim_z_r <= dim_z_nxt;
    end
  end

  gbnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gbnc_dpath #(
    .DIM_LIMIT    (DIM_LIMIT),
    .RADIUS_LIMIT (RADIUS_LIMIT)
  ) u_dpath (
    .clk     (clk),
    .cmd     (cmd),
    .status  (status),
    .dim_x   (dim_x_r),
    .dim_y   (dim_y_r),
    .dim_z   (dim_z_r),
    .coord_x (in_coord_x),
    .coord_y (in_coord_y),
    .coord_z (in_coord_z),
    .radius  (in_radius),
    .cell_id (out_cell_id),
    .cell_x  (out_cell_x),
    .cell_y  (out_cell_y),
    .cell_z  (out_cell_z),
    .last    (out_last)
  );

  assign cell_in_grid = (DIM_W'(out_cell_x) < dim_x_r) && (DIM_W'(out_cell_y) < dim_y_r) &&
                        (DIM_W'(out_cell_z) < dim_z_r);

  `GBNC_ASSERT(a_no_query_while_emit, out_valid |-> in_stall, "query taken during emit")
  `GBNC_ASSERT(a_cell_in_grid, out_valid |-> cell_in_grid, "cell outside grid")
  `GBNC_ASSERT(a_more_after_mid, (out_valid && !out_stall && !out_last) |=> out_valid, "burst cut short")
  `GBNC_ASSERT(a_stop_after_last, (out_valid && !out_stall && out_last) |=> !out_valid, "beat after last")

endmodule

// ===== sim/grid_box_neighbor_cells_test.sv =====
module grid_box_neighbor_cells_test;
  import gbnc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_PRINTS = 20;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    logic [CELL_W-1:0] cz;
    logic              last;
  } cell_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [COORD_W-1:0]   in_coord_x = '0;
  logic [COORD_W-1:0]   in_coord_y = '0;
  logic [COORD_W-1:0]   in_coord_z = '0;
  logic                 in_radius = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ID_W-1:0]      out_cell_id;
  logic [CELL_W-1:0]    out_cell_x;
  logic [CELL_W-1:0]    out_cell_y;
  logic [CELL_W-1:0]    out_cell_z;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  // Shadow copy of the dimension registers, reset values included.
  logic [DIM_W-1:0] grid_dx = 11'd1;
  logic [DIM_W-1:0] grid_dy = 11'd1;
  logic [DIM_W-1:0] grid_dz = 11'd1;

  cell_t expected_cells[$];
  cell_t head;
  int    mismatch_count = 0;
  int    quiet_cycles = 0;
  int    stall_left = 0;
  int    stall_pick;
  bit    input_calm = 1'b0;

  grid_box_neighbor_cells i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_coord_x  (in_coord_x),
    .in_coord_y  (in_coord_y),
    .in_coord_z  (in_coord_z),
    .in_radius   (in_radius),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_cell_id (out_cell_id),
    .out_cell_x  (out_cell_x),
    .out_cell_y  (out_cell_y),
    .out_cell_z  (out_cell_z),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clip_dim(int d);
    return (d > MAX_DIM) ? MAX_DIM : d;
  endfunction

  // Queue every cell of the clamped box, x fastest, then y, then z.
  function automatic void predict_box(logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qy,
                                      logic [COORD_W-1:0] qz, logic rad);
    int dx, dy, dz, px, py, pz, r;
    int x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
    cell_t c;
    dx = clip_dim(grid_dx);
    dy = clip_dim(grid_dy);
    dz = clip_dim(grid_dz);
    px = $signed(qx);
    py = $signed(qy);
    pz = $signed(qz);
    r = rad;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    if (px < 0 || px >= dx || py < 0 || py >= dy || pz < 0 || pz >= dz) return;
    x_lo = (px - r < 0) ? 0 : px - r;
    y_lo = (py - r < 0) ? 0 : py - r;
    z_lo = (pz - r < 0) ? 0 : pz - r;
    x_hi = (px + r > dx - 1) ? dx - 1 : px + r;
    y_hi = (py + r > dy - 1) ? dy - 1 : py + r;
    z_hi = (pz + r > dz - 1) ? dz - 1 : pz + r;
    for (int z = z_lo; z <= z_hi; z++) begin
      for (int y = y_lo; y <= y_hi; y++) begin
        for (int x = x_lo; x <= x_hi; x++) begin
          c.id   = ID_W'(x + y * dx + z * dx * dy);
          c.cx   = CELL_W'(x);
          c.cy   = CELL_W'(y);
          c.cz   = CELL_W'(z);
          c.last = (x == x_hi && y == y_hi && z == z_hi);
          expected_cells.insert(expected_cells.size(), c);
        end
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Compare each accepted result beat with the oldest expected cell.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected beat id=%0d", out_cell_id));
      end else begin
        head = expected_cells.pop_front();
        if (out_cell_id !== head.id)
          report_mismatch($sformatf("cell_id %0d, want %0d", out_cell_id, head.id));
        if (out_cell_x !== head.cx)
          report_mismatch($sformatf("cell_x %0d, want %0d", out_cell_x, head.cx));
        if (out_cell_y !== head.cy)
          report_mismatch($sformatf("cell_y %0d, want %0d", out_cell_y, head.cy));
        if (out_cell_z !== head.cz)
          report_mismatch($sformatf("cell_z %0d, want %0d", out_cell_z, head.cz));
        if (out_last !== head.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, head.last));
      end
    end
  end

  // Receiver back-pressure: long open runs, short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(1, 30);
      end else if (stall_pick < 90) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(1, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("grid_box_neighbor_cells test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (input_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Leaves in_valid high so back-to-back beats need no second assignment.
  task automatic send_query(int qx, int qy, int qz, bit rad);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_x <= COORD_W'(qx);
    in_coord_y <= COORD_W'(qy);
    in_coord_z <= COORD_W'(qz);
    in_radius  <= rad;
    do @(posedge clk); while (in_stall);
    predict_box(COORD_W'(qx), COORD_W'(qy), COORD_W'(qz), rad);
  endtask

  // Drop the input, let every expected cell drain, then let queries
  // with no result finish inside the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIM_X: grid_dx = data;
      CFG_DIM_Y: grid_dy = data;
      CFG_DIM_Z: grid_dz = data;
      default: ;
    endcase
  endtask

  task automatic set_dims(int dx, int dy, int dz);
    wait_drained();
    write_reg(CFG_DIM_X, DIM_W'(dx));
    write_reg(CFG_DIM_Y, DIM_W'(dy));
    write_reg(CFG_DIM_Z, DIM_W'(dz));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_dims();
    send_query(0, 0, 0, 1'b0);
    send_query(0, 0, 0, 1'b1);
    send_query(1, 0, 0, 1'b1);
    send_query(0, -1, 0, 1'b0);
  endtask

  task automatic test_full_grid();
    set_dims(1024, 1024, 1024);
    send_query(0, 0, 0, 1'b1);
    send_query(1023, 1023, 1023, 1'b1);
    send_query(512, 300, 700, 1'b1);
    send_query(1023, 0, 1023, 1'b0);
    send_query(1024, 5, 5, 1'b1);
    send_query(2047, 2047, 2047, 1'b1);
    send_query(-2048, -2048, -2048, 1'b1);
    send_query(-1, 0, 0, 1'b1);
  endtask

  task automatic test_oversized_dims();
    set_dims(2047, 1025, 1500);
    send_query(1023, 1023, 1023, 1'b1);
    send_query(1024, 0, 0, 1'b1);
    send_query(0, 1023, 1023, 1'b0);
  endtask

  task automatic test_empty_axis();
    set_dims(5, 0, 5);
    send_query(0, 0, 0, 1'b1);
    send_query(2, 0, 3, 1'b0);
  endtask

  // A write to the spare index in the middle of a sequence must change nothing.
  task automatic test_unknown_register();
    wait_drained();
    write_reg(CFG_DIM_X, 11'd4);
    write_reg(CFG_DIM_Y, 11'd4);
    write_reg(CFG_NONE, 11'h7FF);
    write_reg(CFG_DIM_Z, 11'd4);
    cfg_valid <= 1'b0;
    send_query(3, 3, 3, 1'b1);
  endtask

  function automatic int pick_axis(int d);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return d - 1;
      default: return $urandom_range(0, d - 1);
    endcase
  endfunction

  task automatic test_random_boxes();
    int dx, dy, dz;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 3) begin
        dx = $urandom_range(1, 2047);
        dy = $urandom_range(1, 2047);
        dz = $urandom_range(1, 2047);
      end else if (phase == 5) begin
        dx = $urandom_range(1, 3);
        dy = $urandom_range(1, 3);
        dz = $urandom_range(1, 3);
      end else begin
        dx = $urandom_range(1, 8);
        dy = $urandom_range(1, 8);
        dz = $urandom_range(1, 8);
      end
      set_dims(dx, dy, dz);
      input_calm = (phase == 1);
      for (int n = 0; n < 27; n++) begin
        if ($urandom_range(0, 4) == 0)
          send_query($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 1));
        else
          send_query(pick_axis(clip_dim(dx)), pick_axis(clip_dim(dy)),
                     pick_axis(clip_dim(dz)), $urandom_range(0, 1));
      end
      input_calm = 1'b0;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_dims();
    test_full_grid();
    test_oversized_dims();
    test_empty_axis();
    test_unknown_register();
    test_random_boxes();
    wait_drained();
    if (mismatch_count == 0)
      $display("grid_box_neighbor_cells test passed");
    else
      $display("grid_box_neighbor_cells test failed");
    $finish;
  end

endmodule
